// File: hdl/lnws_pkg.sv
// Shared types, command codes and strobe timing constants for the LCD nibble sequencer.
package lnws_pkg;

    localparam logic [1:0] CMD_INIT   = 2'd0;
    localparam logic [1:0] CMD_BYTE   = 2'd1;
    localparam logic [1:0] CMD_CHAR   = 2'd2;
    localparam logic [1:0] CMD_CURSOR = 2'd3;

    localparam int STEP_W = 4;

    localparam logic [STEP_W-1:0] INIT_LAST_STEP = 4'd11;
    localparam logic [STEP_W-1:0] BYTE_LAST_STEP = 4'd1;

    localparam logic [15:0] POWER_UP_WAIT_US = 16'd50000;
    localparam logic [15:0] CHAR_BEFORE_US   = 16'd1000;
    localparam logic [2:0]  ENABLE_US        = 3'd5;
    localparam logic [12:0] FIRST_AFTER_US   = 13'd5000;
    localparam logic [12:0] WAKE_AFTER_US    = 13'd200;
    localparam logic [12:0] CMD_AFTER_US     = 13'd2000;
    localparam logic [12:0] CHAR_AFTER_US    = 13'd1000;

    localparam logic [7:0] SET_ADDR_OP       = 8'h80;

    localparam logic [6:0] FIRST_BASE_RESET  = 7'd0;
    localparam logic [6:0] SECOND_BASE_RESET = 7'd64;

    localparam logic CFG_FIRST_BASE  = 1'b0;
    localparam logic CFG_SECOND_BASE = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [3:0]  nibble;
        logic        reg_select;
        logic [15:0] wait_before_us;
        logic [2:0]  enable_high_us;
        logic [12:0] wait_after_us;
        logic        last;
    } strobe_t;

    typedef struct packed {
        logic              accept;
        logic              load;
        logic [STEP_W-1:0] step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic final_step;
    } dp_status_t;

    // Nibble sequence of the power-up run: wake-up nibbles and the four-bit
    // switch, then function set, display on, entry mode, clear.
    function automatic logic [3:0] init_nibble(input logic [STEP_W-1:0] step);
        logic [3:0] n;
        unique case (step)
            4'd0, 4'd1, 4'd2: n = 4'h3;
            4'd3, 4'd4:       n = 4'h2;
            4'd5:             n = 4'h8;
            4'd7:             n = 4'hC;
            4'd9:             n = 4'h6;
            4'd11:            n = 4'h1;
            default:          n = 4'h0;
        endcase
        return n;
    endfunction

    function automatic logic [12:0] init_after(input logic [STEP_W-1:0] step);
        logic [12:0] a;
        unique case (step)
            4'd0:                    a = FIRST_AFTER_US;
            4'd1, 4'd2, 4'd3:        a = WAKE_AFTER_US;
            4'd5, 4'd7, 4'd9, 4'd11: a = CMD_AFTER_US;
            default:                 a = 13'd0;
        endcase
        return a;
    endfunction

endpackage

// File: hdl/lnws_ctrl.sv
// Controller: request handshake, strobe step counter and output valid.
module lnws_ctrl
    import lnws_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    logic              accept;
    logic              load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // outputs
    always_comb
    begin
        in_ready = 1'b0;
        load     = 1'b0;
        unique case (state_reg)
            ST_IDLE: in_ready = 1'b1;
            ST_EMIT: load     = !out_valid_reg || out_ready;
            default: in_ready = 1'b0;
        endcase
        accept     = in_valid && in_ready;
        out_valid  = out_valid_reg;
        cmd.accept = accept;
        cmd.load   = load;
        cmd.step   = step_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_EMIT;
            ST_EMIT: if (load && status.final_step) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        priority if (accept)
            step_next = '0;
        else if (load)
            step_next = step_reg + 1'b1;
        else
            step_next = step_reg;

        priority if (load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

endmodule

// File: hdl/lnws_dp.sv
// Datapath: line base registers, request latch, strobe decode and output register.
module lnws_dp
    import lnws_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [6:0] cfg_data,
    input  logic [1:0] command,
    input  logic [7:0] byte_value,
    input  logic [1:0] line,
    input  logic [5:0] column,
    input  ctrl_cmd_t  cmd,
    output dp_status_t status,
    output strobe_t    strobe
);

    logic [6:0] first_base_reg;
    logic [6:0] second_base_reg;
    logic [1:0] cmd_reg;
    logic [7:0] byte_reg, byte_next;
    strobe_t    strobe_reg, strobe_next;
    logic [6:0] base;
    logic [6:0] addr;
    logic       is_init;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_base_reg  <= FIRST_BASE_RESET;
            second_base_reg <= SECOND_BASE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FIRST_BASE:  first_base_reg  <= cfg_data;
                CFG_SECOND_BASE: second_base_reg <= cfg_data;
                default:         first_base_reg  <= first_base_reg;
            endcase
        end
    end

    always_comb
    begin
        base = (line == 2'd1) ? first_base_reg : second_base_reg;
        addr = base + {1'b0, column};
        byte_next = (command == CMD_CURSOR) ? (SET_ADDR_OP | {1'b0, addr}) : byte_value;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cmd_reg  <= command;
            byte_reg <= byte_next;
        end
        if (cmd.load)
            strobe_reg <= strobe_next;
    end

    always_comb
    begin
        is_init = (cmd_reg == CMD_INIT);
        status.final_step = is_init ? (cmd.step == INIT_LAST_STEP)
                                    : (cmd.step == BYTE_LAST_STEP);

        strobe_next.enable_high_us = ENABLE_US;
        strobe_next.last           = status.final_step;
        if (is_init)
        begin
            strobe_next.nibble         = init_nibble(cmd.step);
            strobe_next.reg_select     = 1'b0;
            strobe_next.wait_before_us = (cmd.step == '0) ? POWER_UP_WAIT_US : 16'd0;
            strobe_next.wait_after_us  = init_after(cmd.step);
        end
        else
        begin
            // high nibble on step 0, low nibble on step 1
            strobe_next.nibble     = cmd.step[0] ? byte_reg[3:0] : byte_reg[7:4];
            strobe_next.reg_select = (cmd_reg == CMD_CHAR);
            strobe_next.wait_before_us =
                (!cmd.step[0] && cmd_reg == CMD_CHAR) ? CHAR_BEFORE_US : 16'd0;
            if (!cmd.step[0])
                strobe_next.wait_after_us = 13'd0;
            else if (cmd_reg == CMD_CHAR)
                strobe_next.wait_after_us = CHAR_AFTER_US;
            else
                strobe_next.wait_after_us = CMD_AFTER_US;
        end
    end

    assign strobe = strobe_reg;

endmodule

// File: hdl/lcd_nibble_write_sequencer.sv
// Top level of the 4-bit character LCD write sequencer.
// Flow: a request is taken while idle; its first strobe is then loaded into the output
//   register, then one strobe per cycle while the sink is ready.
// Strobes: init gives 12 strobes, other commands 2; the step counter in the
//   controller sets this, and a new request is taken only once the controller is idle.
// Reset: rst_n clears state asynchronously; line bases return to 0 and 64.
module lcd_nibble_write_sequencer
    import lnws_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    // configuration writes: index 0 first line base, 1 second line base
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data,

    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] command, [9:2] byte_value, [11:10] line, [17:12] column, rest zero
    input  logic [23:0] s_axis_tdata,

    // strobe stream, one transfer per enable strobe
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] nibble, [19:4] wait_before_us, [22:20] enable_high_us,
    // [35:23] wait_after_us, rest zero
    output logic [39:0] m_axis_tdata,
    // [0] reg_select
    output logic        m_axis_tuser,
    output logic        m_axis_tlast
);

    ctrl_cmd_t  cmd;
    dp_status_t status;
    strobe_t    strobe;

    // Controller sequences the strobe steps and owns both handshakes.
    lnws_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath holds the request and decodes each step into a strobe.
    lnws_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .command    (s_axis_tdata[1:0]),
        .byte_value (s_axis_tdata[9:2]),
        .line       (s_axis_tdata[11:10]),
        .column     (s_axis_tdata[17:12]),
        .cmd        (cmd),
        .status     (status),
        .strobe     (strobe)
    );

    assign m_axis_tdata = {4'b0, strobe.wait_after_us, strobe.enable_high_us,
                           strobe.wait_before_us, strobe.nibble};
    assign m_axis_tuser = strobe.reg_select;
    assign m_axis_tlast = strobe.last;

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the 4-bit character LCD write sequencer.
`timescale 1ns / 1ps

module testbench
    import lnws_pkg::*;
();

    // run length guard, sized well above the slowest legal run
    localparam int unsigned CYCLE_LIMIT      = 400000;
    localparam int          RESET_CYCLES     = 7;
    localparam int          DRAIN_SLACK      = 16;
    localparam int          SINK_HOLD_CYCLES = 400;
    localparam int          PHASES           = 6;
    localparam int          ITEMS_PER_PHASE  = 68;

    // controller instruction bytes and nibbles of the power-up run
    localparam logic [3:0] WAKE_NIBBLE     = 4'h3;
    localparam logic [3:0] FOUR_BIT_NIBBLE = 4'h2;
    localparam logic [7:0] FUNCTION_SET    = 8'h28;
    localparam logic [7:0] DISPLAY_ON      = 8'h0C;
    localparam logic [7:0] ENTRY_MODE      = 8'h06;
    localparam logic [7:0] BLANK_SCREEN    = 8'h01;
    localparam logic [7:0] DDRAM_ADDR_OP   = 8'h80;

    // strobe timing in microseconds
    localparam logic [15:0] T_POWER_BEFORE = 16'd50000;
    localparam logic [12:0] T_POWER_AFTER  = 13'd5000;
    localparam logic [12:0] T_WAKE_AFTER   = 13'd200;
    localparam logic [12:0] T_CMD_AFTER    = 13'd2000;
    localparam logic [12:0] T_CHAR_WAIT    = 13'd1000;
    localparam logic [2:0]  T_ENABLE       = 3'd5;

    typedef enum int {
        SINK_ALWAYS,
        SINK_RANDOM,
        SINK_PERIODIC,
        SINK_RARE
    } sink_mode_e;

    // Expected strobe stream: expands each accepted request into its strobes
    // and checks every strobe that leaves the block against the oldest one.
    class strobe_tracker;
        strobe_t        due_strobes[$];
        logic [6:0]     line_one_base;
        logic [6:0]     line_two_base;
        int unsigned    faults;
        int unsigned    strobes_seen;

        function new();
            line_one_base = 7'd0;
            line_two_base = 7'd64;
            faults        = 0;
            strobes_seen  = 0;
        endfunction

        function void set_base(input logic idx, input logic [6:0] value);
            if (idx == CFG_FIRST_BASE)
                line_one_base = value;
            else
                line_two_base = value;
        endfunction

        function void push_strobe(input logic [3:0] nib, input logic rs,
                                  input logic [15:0] lead_us, input logic [12:0] after);
            strobe_t s;
            s.nibble         = nib;
            s.reg_select     = rs;
            s.wait_before_us = lead_us;
            s.enable_high_us = T_ENABLE;
            s.wait_after_us  = after;
            s.last           = 1'b0;
            due_strobes.push_back(s);
        endfunction

        // high nibble first; the wait before sits on the first, the wait after on the second
        function void push_byte(input logic [7:0] b, input logic rs,
                                input logic [15:0] lead_us, input logic [12:0] after);
            push_strobe(b[7:4], rs, lead_us, 13'd0);
            push_strobe(b[3:0], rs, 16'd0, after);
        endfunction

        function void take_request(input logic [1:0] cmd, input logic [7:0] b,
                                   input logic [1:0] line, input logic [5:0] col);
            logic [6:0] base;
            logic [6:0] addr;
            strobe_t    tail;
            case (cmd)
                CMD_INIT:
                begin
                    push_strobe(WAKE_NIBBLE, 1'b0, T_POWER_BEFORE, T_POWER_AFTER);
                    push_strobe(WAKE_NIBBLE, 1'b0, 16'd0, T_WAKE_AFTER);
                    push_strobe(WAKE_NIBBLE, 1'b0, 16'd0, T_WAKE_AFTER);
                    push_strobe(FOUR_BIT_NIBBLE, 1'b0, 16'd0, T_WAKE_AFTER);
                    push_byte(FUNCTION_SET, 1'b0, 16'd0, T_CMD_AFTER);
                    push_byte(DISPLAY_ON, 1'b0, 16'd0, T_CMD_AFTER);
                    push_byte(ENTRY_MODE, 1'b0, 16'd0, T_CMD_AFTER);
                    push_byte(BLANK_SCREEN, 1'b0, 16'd0, T_CMD_AFTER);
                end
                CMD_BYTE:
                    push_byte(b, 1'b0, 16'd0, T_CMD_AFTER);
                CMD_CHAR:
                    push_byte(b, 1'b1, {3'd0, T_CHAR_WAIT}, T_CHAR_WAIT);
                default:
                begin
                    // any line other than one picks the second base; sum wraps at 128
                    base = (line == 2'd1) ? line_one_base : line_two_base;
                    addr = base + {1'b0, col};
                    push_byte(DDRAM_ADDR_OP | {1'b0, addr}, 1'b0, 16'd0, T_CMD_AFTER);
                end
            endcase
            tail      = due_strobes.pop_back();
            tail.last = 1'b1;
            due_strobes.push_back(tail);
        endfunction

        function void check_strobe(input logic [3:0] nib, input logic rs,
                                   input logic [15:0] lead_us, input logic [2:0] en,
                                   input logic [12:0] after, input logic lst);
            strobe_t exp;
            logic    bad;
            strobes_seen++;
            if (due_strobes.size() == 0)
            begin
                faults++;
                if (faults <= 10)
                    $display("strobe %0d arrived with none outstanding: nib=%h rs=%b",
                             strobes_seen, nib, rs);
                return;
            end
            exp = due_strobes.pop_front();
            bad = (nib !== exp.nibble) || (rs !== exp.reg_select) ||
                  (lead_us !== exp.wait_before_us) || (en !== exp.enable_high_us) ||
                  (after !== exp.wait_after_us) || (lst !== exp.last);
            if (bad)
            begin
                faults++;
                if (faults <= 10)
                begin
                    $display("strobe %0d wrong: exp nib=%h rs=%b before=%0d en=%0d after=%0d last=%b",
                             strobes_seen, exp.nibble, exp.reg_select, exp.wait_before_us,
                             exp.enable_high_us, exp.wait_after_us, exp.last);
                    $display("            got nib=%h rs=%b before=%0d en=%0d after=%0d last=%b",
                             nib, rs, lead_us, en, after, lst);
                end
            end
        endfunction

        function int outstanding();
            return due_strobes.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [6:0]  cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // [1:0] command, [9:2] byte_value, [11:10] line, [17:12] column
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // [3:0] nibble, [19:4] before, [22:20] enable, [35:23] after
    logic        m_axis_tuser;   // [0] reg_select
    logic        m_axis_tlast;

    strobe_tracker tracker;
    int unsigned   cycle_count = 0;
    sink_mode_e    sink_mode   = SINK_ALWAYS;
    bit            sink_hold_req = 1'b0;

    lcd_nibble_write_sequencer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("lcd_nibble_write_sequencer: mismatch");
            $finish;
        end
    end

    // Sink side. A hold request from the stimulus makes the sink refuse strobes
    // for a long stretch so the block backs up and stalls its request input.
    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_hold_req)
            begin
                sink_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (SINK_HOLD_CYCLES - 1) @(posedge clk);
            end
            else
            begin
                case (sink_mode)
                    SINK_ALWAYS:   m_axis_tready <= 1'b1;
                    SINK_RANDOM:   m_axis_tready <= 1'($urandom_range(0, 1));
                    SINK_PERIODIC: m_axis_tready <= ((cycle_count % 7) < 4);
                    default:       m_axis_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // strobe monitor: values sampled at the edge are the ones that made the transfer
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_strobe(m_axis_tdata[3:0], m_axis_tuser, m_axis_tdata[19:4],
                                 m_axis_tdata[22:20], m_axis_tdata[35:23], m_axis_tlast);
    end

    // Offer one request and hold it until the transfer; tvalid stays up afterwards
    // so a following call keeps the burst going.
    task automatic send_request(input logic [1:0] cmd, input logic [7:0] b,
                                input logic [1:0] line, input logic [5:0] col);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, col, line, b, cmd};
        do
            @(posedge clk);
        while (!s_axis_tready);
        tracker.take_request(cmd, b, line, col);
    endtask

    task automatic send_random();
        int          pick;
        logic [1:0]  cmd;
        logic [1:0]  line;
        logic [5:0]  col;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            cmd = CMD_INIT;
        else if (pick < 40)
            cmd = CMD_BYTE;
        else if (pick < 72)
            cmd = CMD_CHAR;
        else
            cmd = CMD_CURSOR;
        // mostly legal lines and columns, some out of range to hit the fallbacks
        line = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3))
                                           : 2'($urandom_range(1, 2));
        col  = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                           : 6'($urandom_range(0, 39));
        send_request(cmd, 8'($urandom_range(0, 255)), line, col);
    endtask

    // gap between bursts; zero keeps tvalid up
    task automatic pause_sender(input int cycles);
        if (cycles > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // stop offering and wait until every outstanding strobe has gone out
    task automatic drain_strobes();
        s_axis_tvalid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    // only called with the block idle; the extra edge keeps cfg_we pulses apart
    task automatic write_base(input logic idx, input logic [6:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        tracker.set_base(idx, value);
        @(posedge clk);
    endtask

    initial
    begin
        int          burst_left;
        logic [6:0]  one_base;
        logic [6:0]  two_base;
        tracker = new();
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_FIRST_BASE;
        cfg_data      <= 7'd0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 24'd0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed part with reset line bases: every command, field extremes
        send_request(CMD_INIT, 8'h00, 2'd0, 6'd0);
        send_request(CMD_INIT, 8'hFF, 2'd3, 6'd63);   // ignored fields at max
        send_request(CMD_BYTE, 8'h00, 2'd0, 6'd0);
        send_request(CMD_BYTE, 8'hFF, 2'd3, 6'd63);
        send_request(CMD_BYTE, 8'h01, 2'd1, 6'd0);
        send_request(CMD_CHAR, 8'h00, 2'd1, 6'd0);
        send_request(CMD_CHAR, 8'hFF, 2'd2, 6'd0);
        send_request(CMD_CHAR, 8'h41, 2'd1, 6'd0);
        send_request(CMD_CURSOR, 8'hFF, 2'd1, 6'd0);
        send_request(CMD_CURSOR, 8'h00, 2'd2, 6'd0);
        send_request(CMD_CURSOR, 8'h00, 2'd1, 6'd39);
        send_request(CMD_CURSOR, 8'h00, 2'd2, 6'd39);
        send_request(CMD_CURSOR, 8'h00, 2'd2, 6'd63);  // column beyond the line
        send_request(CMD_CURSOR, 8'h00, 2'd0, 6'd5);   // line zero falls to second base
        send_request(CMD_CURSOR, 8'h00, 2'd3, 6'd63);
        send_request(CMD_BYTE, 8'h5A, 2'd1, 6'd0);
        drain_strobes();

        // extreme bases so the address sum wraps
        write_base(CFG_FIRST_BASE, 7'd127);
        write_base(CFG_SECOND_BASE, 7'd0);
        send_request(CMD_CURSOR, 8'h00, 2'd1, 6'd1);   // 127 + 1 wraps to 0
        send_request(CMD_CURSOR, 8'h00, 2'd1, 6'd63);
        send_request(CMD_CURSOR, 8'h00, 2'd2, 6'd63);
        send_request(CMD_CURSOR, 8'h00, 2'd3, 6'd0);
        send_request(CMD_CHAR, 8'hA5, 2'd1, 6'd0);
        send_request(CMD_INIT, 8'h00, 2'd1, 6'd0);

        // random phases, each setting its line bases and a sink pattern
        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain_strobes();
            case (phase)
                0:
                begin
                    one_base = 7'd0;
                    two_base = 7'd127;
                end
                1:
                begin
                    one_base = 7'd127;
                    two_base = 7'd127;
                end
                2:
                begin
                    one_base = 7'd0;
                    two_base = 7'd0;
                end
                3:
                begin
                    one_base = 7'd0;
                    two_base = 7'd64;
                end
                default:
                begin
                    one_base = 7'($urandom_range(0, 127));
                    two_base = 7'($urandom_range(0, 127));
                end
            endcase
            write_base(CFG_FIRST_BASE, one_base);
            write_base(CFG_SECOND_BASE, two_base);
            sink_mode = sink_mode_e'(phase % 4);

            // back up the block: sink refuses while requests keep coming
            if (phase == 2)
                sink_hold_req = 1'b1;

            burst_left = 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (burst_left == 0)
                begin
                    // first phase runs with no sender gaps at all
                    if (phase != 0)
                        pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
                    burst_left = $urandom_range(1, 12);
                end
                send_random();
                burst_left--;
            end
        end

        drain_strobes();
        if (tracker.faults == 0 && tracker.outstanding() == 0)
            $display("lcd_nibble_write_sequencer: match");
        else
            $display("lcd_nibble_write_sequencer: mismatch");
        $finish;
    end

endmodule

// File: files.f
hdl/lnws_pkg.sv
hdl/lnws_ctrl.sv
hdl/lnws_dp.sv
hdl/lcd_nibble_write_sequencer.sv
tb/sv/testbench.sv
